/* design/prs_pkg.sv */
// Package with the shared types and constants of the task scheduler.
package prs_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_DELAY   = 3'd1,
    OP_LOCK    = 3'd2,
    OP_UNLOCK  = 3'd3,
    OP_ADD     = 3'd4,
    OP_READY   = 3'd5,
    OP_UNREADY = 3'd6,
    OP_START   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SLEEP,
    ST_SLICE,
    ST_SCHED,
    ST_OUT
  } state_e;

  localparam int unsigned LOCK_MAX = 255;
  localparam int unsigned SLICE_RESET = 10;

  typedef struct packed {
    logic load;
    logic sleep_step;
    logic slice_step;
    logic sched;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic sleep_done;
    logic tick_op;
  } status_t;

endpackage

/* design/prs_ctrl.sv */
// Controller state machine that sequences one operation through the datapath.
module prs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  prs_pkg::status_t  status_i,
  output prs_pkg::cmd_t     cmd_o
);

  prs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_q)
      prs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_d = prs_pkg::ST_SLEEP;
        end
      end
      prs_pkg::ST_SLEEP: begin
        if (!status_i.tick_op) begin
          state_d = prs_pkg::ST_SCHED;
        end else if (status_i.sleep_done) begin
          state_d = prs_pkg::ST_SLICE;
        end else begin
          cmd_o.sleep_step = 1'b1;
        end
      end
      prs_pkg::ST_SLICE: begin
        cmd_o.slice_step = 1'b1;
        state_d = prs_pkg::ST_SCHED;
      end
      prs_pkg::ST_SCHED: begin
        cmd_o.sched = 1'b1;
        cmd_o.out_load = 1'b1;
        state_d = prs_pkg::ST_OUT;
      end
      prs_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_d = prs_pkg::ST_IDLE;
        end
      end
      default: state_d = prs_pkg::ST_IDLE;
    endcase
  end

endmodule

/* design/prs_dp.sv */
// Datapath holding the ready lists, sleep list, counters and result register.
module prs_dp #(
  parameter int unsigned NUM_TASKS   = 8,
  parameter int unsigned PRIO_LEVELS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prs_pkg::cmd_t     cmd_i,
  output prs_pkg::status_t  status_o,
  input  logic              cfg_valid,
  input  logic [7:0]        cfg_data,
  input  logic [2:0]        op_i,
  input  logic [2:0]        task_id_i,
  input  logic [4:0]        task_priority_i,
  input  logic [15:0]       delay_ticks_i,
  output logic [2:0]        next_task_o,
  output logic              switch_request_o,
  output logic              any_ready_o,
  output logic [2:0]        running_task_o,
  output logic [7:0]        lock_depth_o
);

  localparam int unsigned TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int unsigned PW = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
  localparam int unsigned LW = $clog2(NUM_TASKS + 1);

  // Each priority list is a row of positions; lists are kept per task by rank.
  logic [PW-1:0] prio_q [NUM_TASKS];
  logic [15:0]   dly_q  [NUM_TASKS];
  logic [7:0]    slc_q  [NUM_TASKS];
  logic          rdy_q  [NUM_TASKS];
  logic [LW-1:0] rpos_q [NUM_TASKS];
  logic          slp_q  [NUM_TASKS];
  logic [LW-1:0] spos_q [NUM_TASKS];
  logic [TW-1:0] cur_q;
  logic [7:0]    lock_q, slen_q;
  logic [2:0]    op_q;
  logic [TW-1:0] scan_q;
  logic          scan_done_q;
  logic          run_sched_q;
  logic [2:0]    nxt_q;
  logic          sw_q, any_q;

  // Find the head of the highest non-empty list, by rank 0.
  logic          found;
  logic [TW-1:0] best;
  logic [PW-1:0] bestp;
  always_comb begin
    found = 1'b0;
    best  = '0;
    bestp = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (rdy_q[i] && rpos_q[i] == '0 && (!found || prio_q[i] < bestp)) begin
        found = 1'b1;
        best  = TW'(i);
        bestp = prio_q[i];
      end
    end
  end

  logic any_rdy;
  always_comb begin
    any_rdy = 1'b0;
    for (int i = 0; i < NUM_TASKS; i++) any_rdy |= rdy_q[i];
  end

  // Number of tasks in the current task's list, for slice rotation.
  logic [LW-1:0] cur_len;
  always_comb begin
    cur_len = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (rdy_q[i] && prio_q[i] == prio_q[cur_q]) cur_len = cur_len + LW'(1);
    end
  end

  assign status_o.sleep_done = scan_done_q;
  assign status_o.tick_op    = (op_q == prs_pkg::OP_TICK);

  function automatic logic [PW-1:0] sat_prio(input logic [4:0] p);
    if (32'(p) >= PRIO_LEVELS) return PW'(PRIO_LEVELS - 1);
    return PW'(p);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        rdy_q[i] <= 1'b0;
        slp_q[i] <= 1'b0;
        dly_q[i] <= '0;
        prio_q[i] <= '0;
        slc_q[i] <= '0;
        rpos_q[i] <= '0;
        spos_q[i] <= '0;
      end
      cur_q <= '0;
      lock_q <= '0;
      slen_q <= 8'(prs_pkg::SLICE_RESET);
      op_q <= prs_pkg::OP_LOCK;
      scan_q <= '0;
      scan_done_q <= 1'b0;
      run_sched_q <= 1'b0;
      nxt_q <= '0;
      sw_q <= 1'b0;
      any_q <= 1'b0;
    end else begin
      if (cfg_valid) slen_q <= cfg_data;
      if (cmd_i.load) begin
        op_q <= op_i;
        scan_q <= '0;
        scan_done_q <= 1'b0;
        run_sched_q <= 1'b0;
        // Non-tick list operations complete at once.
        case (prs_pkg::op_e'(op_i))
          prs_pkg::OP_DELAY: begin
            for (int i = 0; i < NUM_TASKS; i++) begin
              if (slp_q[i] && spos_q[i] < spos_q[cur_q]) spos_q[i] <= spos_q[i] + LW'(1);
              else if (!slp_q[cur_q] && slp_q[i]) spos_q[i] <= spos_q[i] + LW'(1);
              if (rdy_q[cur_q] && rdy_q[i] && prio_q[i] == prio_q[cur_q]
                  && rpos_q[i] > rpos_q[cur_q]) rpos_q[i] <= rpos_q[i] - LW'(1);
            end
            slp_q[cur_q] <= 1'b1;
            spos_q[cur_q] <= '0;
            dly_q[cur_q] <= delay_ticks_i;
            rdy_q[cur_q] <= 1'b0;
            run_sched_q <= (lock_q == '0);
          end
          prs_pkg::OP_LOCK: begin
            if (32'(lock_q) < prs_pkg::LOCK_MAX) lock_q <= lock_q + 8'd1;
          end
          prs_pkg::OP_UNLOCK: begin
            if (lock_q != '0) begin
              lock_q <= lock_q - 8'd1;
              run_sched_q <= (lock_q == 8'd1);
            end
          end
          prs_pkg::OP_ADD: begin
            if (32'(task_id_i) < NUM_TASKS) begin
              for (int i = 0; i < NUM_TASKS; i++) begin
                if (slp_q[TW'(task_id_i)] && slp_q[i]
                    && spos_q[i] > spos_q[TW'(task_id_i)]) spos_q[i] <= spos_q[i] - LW'(1);
                if (rdy_q[i] && i != 32'(task_id_i)) begin
                  if (prio_q[i] == sat_prio(task_priority_i)) begin
                    if (!(rdy_q[TW'(task_id_i)] && prio_q[TW'(task_id_i)] == prio_q[i]
                        && rpos_q[i] > rpos_q[TW'(task_id_i)]))
                      rpos_q[i] <= rpos_q[i] + LW'(1);
                  end else if (rdy_q[TW'(task_id_i)] && prio_q[i] == prio_q[TW'(task_id_i)]
                      && rpos_q[i] > rpos_q[TW'(task_id_i)]) begin
                    rpos_q[i] <= rpos_q[i] - LW'(1);
                  end
                end
              end
              prio_q[TW'(task_id_i)] <= sat_prio(task_priority_i);
              slc_q[TW'(task_id_i)] <= slen_q;
              dly_q[TW'(task_id_i)] <= '0;
              slp_q[TW'(task_id_i)] <= 1'b0;
              rdy_q[TW'(task_id_i)] <= 1'b1;
              rpos_q[TW'(task_id_i)] <= '0;
            end
          end
          prs_pkg::OP_READY: begin
            if (32'(task_id_i) < NUM_TASKS && !rdy_q[TW'(task_id_i)]) begin
              for (int i = 0; i < NUM_TASKS; i++) begin
                if (rdy_q[i] && prio_q[i] == prio_q[TW'(task_id_i)])
                  rpos_q[i] <= rpos_q[i] + LW'(1);
              end
              rdy_q[TW'(task_id_i)] <= 1'b1;
              rpos_q[TW'(task_id_i)] <= '0;
            end
          end
          prs_pkg::OP_UNREADY: begin
            if (32'(task_id_i) < NUM_TASKS && rdy_q[TW'(task_id_i)]) begin
              for (int i = 0; i < NUM_TASKS; i++) begin
                if (rdy_q[i] && prio_q[i] == prio_q[TW'(task_id_i)]
                    && rpos_q[i] > rpos_q[TW'(task_id_i)]) rpos_q[i] <= rpos_q[i] - LW'(1);
              end
              rdy_q[TW'(task_id_i)] <= 1'b0;
            end
          end
          prs_pkg::OP_START: run_sched_q <= 1'b1;
          default: ;
        endcase
      end
      // One sleep-list position per cycle, walked in list order.
      if (cmd_i.sleep_step) begin
        logic          hit;
        logic [TW-1:0] t;
        hit = 1'b0;
        t = '0;
        for (int i = 0; i < NUM_TASKS; i++) begin
          if (slp_q[i] && spos_q[i] == LW'(scan_q)) begin
            hit = 1'b1;
            t = TW'(i);
          end
        end
        if (!hit) begin
          scan_done_q <= 1'b1;
        end else if (dly_q[t] == 16'd1) begin
          dly_q[t] <= '0;
          slp_q[t] <= 1'b0;
          for (int i = 0; i < NUM_TASKS; i++) begin
            if (slp_q[i] && spos_q[i] > spos_q[t]) spos_q[i] <= spos_q[i] - LW'(1);
            if (!rdy_q[t] && rdy_q[i] && prio_q[i] == prio_q[t])
              rpos_q[i] <= rpos_q[i] + LW'(1);
          end
          if (!rdy_q[t]) begin
            rdy_q[t] <= 1'b1;
            rpos_q[t] <= '0;
          end
        end else begin
          dly_q[t] <= dly_q[t] - 16'd1;
          if (32'(scan_q) == NUM_TASKS - 1) scan_done_q <= 1'b1;
          else scan_q <= scan_q + TW'(1);
        end
      end
      if (cmd_i.slice_step) begin
        run_sched_q <= (lock_q == '0);
        if (slc_q[cur_q] == 8'd1) begin
          slc_q[cur_q] <= slen_q;
          if (rdy_q[cur_q] && rpos_q[cur_q] == '0 && cur_len > LW'(1)) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
              if (rdy_q[i] && prio_q[i] == prio_q[cur_q]) rpos_q[i] <= rpos_q[i] - LW'(1);
            end
            rpos_q[cur_q] <= cur_len - LW'(1);
          end
        end else begin
          slc_q[cur_q] <= slc_q[cur_q] - 8'd1;
        end
      end
      if (cmd_i.sched) begin
        sw_q <= 1'b0;
        if (run_sched_q && found && best != cur_q) begin
          cur_q <= best;
          sw_q <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        nxt_q <= found ? 3'(best) : 3'd0;
        any_q <= any_rdy;
      end
    end
  end

  assign next_task_o      = nxt_q;
  assign switch_request_o = sw_q;
  assign any_ready_o      = any_q;
  assign running_task_o   = 3'(cur_q);
  assign lock_depth_o     = lock_q;

endmodule

/* design/priority_round_robin_task_scheduler.sv */
// Top level of the priority task scheduler with round-robin time slicing.
// One word in on in_valid/in_ready gives one word out on out_valid/out_ready.
// The op field selects tick, delay, lock, unlock, add, ready, unready or start.
// List operations pass from acceptance through SLEEP and SCHED to the result word.
// A tick walks the sleep list one task a cycle in SLEEP, then steps the slice
// counter in SLICE and schedules in SCHED before the result word.
// One operation is in flight at a time; a new word is taken only after the
// result word is taken. While out_ready is low the result word holds.
// Reset empties all lists, clears the lock and the current task, and loads
// a slice length of ten ticks. The user writes the slice length on cfg_valid /
// cfg_ready only while the block is idle; the block leaves this to the user. cfg_ready is always high.
module priority_round_robin_task_scheduler #(
  parameter int unsigned NUM_TASKS   = 8,
  parameter int unsigned PRIO_LEVELS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op_i,
  input  logic [2:0]  task_id_i,
  input  logic [4:0]  task_priority_i,
  input  logic [15:0] delay_ticks_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  next_task_o,
  output logic        switch_request_o,
  output logic        any_ready_o,
  output logic [2:0]  running_task_o,
  output logic [7:0]  lock_depth_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  prs_pkg::cmd_t    cmd;
  prs_pkg::status_t status;

  assign cfg_ready = 1'b1;

  prs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .out_ready, .out_valid,
    .status_i(status), .cmd_o(cmd)
  );

  prs_dp #(.NUM_TASKS(NUM_TASKS), .PRIO_LEVELS(PRIO_LEVELS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .cfg_valid(cfg_valid && cfg_ready), .cfg_data,
    .op_i, .task_id_i, .task_priority_i, .delay_ticks_i,
    .next_task_o, .switch_request_o, .any_ready_o, .running_task_o, .lock_depth_o
  );

endmodule

/* design/prs_checker.sv */
// Port-level checker for the scheduler, bound to the top level.
module prs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       switch_request_o,
  input logic       any_ready_o,
  input logic [7:0] lock_depth_o
);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken while result pending");

  a_switch_needs_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && switch_request_o |-> any_ready_o) else $error("switch with nothing ready");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(lock_depth_o))
    else $error("result changed while stalled");

  a_lock_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> lock_depth_o == $past(lock_depth_o)
      || lock_depth_o == $past(lock_depth_o) + 8'd1
      || lock_depth_o == $past(lock_depth_o) - 8'd1)
    else $error("lock depth jumped");

endmodule

bind priority_round_robin_task_scheduler prs_checker u_prs_checker (
  .clk_i, .rst_ni, .in_valid, .in_ready, .out_valid, .out_ready,
  .switch_request_o, .any_ready_o, .lock_depth_o
);

/* test/tb_priority_round_robin_task_scheduler.sv */
// Self-checking testbench of the priority round-robin task scheduler.
module tb_priority_round_robin_task_scheduler;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTASK = 8;
  localparam int NPRIO = 32;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [2:0] nxt;
    logic       sw;
    logic       any;
    logic [2:0] run;
    logic [7:0] lk;
  } sched_res_t;

  typedef struct {
    prs_pkg::op_e op;
    logic [2:0]   id;
    logic [4:0]   prio;
    logic [15:0]  dly;
    bit           typed;
    sched_res_t   res;
  } sched_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  op_i = '0;
  logic [2:0]  task_id_i = '0;
  logic [4:0]  task_priority_i = '0;
  logic [15:0] delay_ticks_i = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  next_task_o;
  logic        switch_request_o;
  logic        any_ready_o;
  logic [2:0]  running_task_o;
  logic [7:0]  lock_depth_o;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  priority_round_robin_task_scheduler i_dut (
    .clk_i, .rst_ni, .in_valid, .in_ready, .op_i, .task_id_i, .task_priority_i,
    .delay_ticks_i, .out_valid, .out_ready, .next_task_o, .switch_request_o,
    .any_ready_o, .running_task_o, .lock_depth_o, .cfg_valid, .cfg_ready, .cfg_data
  );

  always #4 clk_i = ~clk_i;

  // Scheduler state as predicted.
  logic [7:0]  slice_len;
  logic [4:0]  task_prio [NTASK];
  logic [15:0] sleep_cnt [NTASK];
  logic [7:0]  slice_cnt [NTASK];
  logic [2:0]  rdy_q [NPRIO][NTASK];
  int          rdy_len [NPRIO];
  logic [2:0]  slp_q [NTASK];
  int          slp_len;
  logic [2:0]  cur_task;
  logic [7:0]  lock_cnt;
  bit [NTASK-1:0] added;

  sched_res_t  pending_q[$];
  int          errors = 0;
  int          cycles = 0;
  bit          hold_req = 1'b0;

  function automatic int rdy_find(int p, int t);
    for (int i = 0; i < rdy_len[p]; i++) if (rdy_q[p][i] == t) return i;
    return -1;
  endfunction

  function automatic void rdy_del(int p, int i);
    for (int j = i; j < rdy_len[p] - 1; j++) rdy_q[p][j] = rdy_q[p][j+1];
    rdy_len[p]--;
  endfunction

  function automatic void rdy_drop(int t);
    int i;
    i = rdy_find(task_prio[t], t);
    if (i >= 0) rdy_del(task_prio[t], i);
  endfunction

  function automatic void rdy_push_head(int t);
    int p;
    p = task_prio[t];
    if (rdy_find(p, t) < 0 && rdy_len[p] < NTASK) begin
      for (int j = rdy_len[p]; j > 0; j--) rdy_q[p][j] = rdy_q[p][j-1];
      rdy_q[p][0] = 3'(t);
      rdy_len[p]++;
    end
  endfunction

  function automatic void slp_del(int i);
    for (int j = i; j < slp_len - 1; j++) slp_q[j] = slp_q[j+1];
    slp_len--;
  endfunction

  function automatic void slp_drop(int t);
    for (int i = 0; i < slp_len; i++) begin
      if (slp_q[i] == t) begin
        slp_del(i);
        return;
      end
    end
  endfunction

  function automatic bit top_task(output logic [2:0] t);
    t = '0;
    for (int p = 0; p < NPRIO; p++) begin
      if (rdy_len[p] != 0) begin
        t = rdy_q[p][0];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic pick_task(bit ignore_lock);
    logic [2:0] t;
    if (!ignore_lock && lock_cnt != 0) return 1'b0;
    if (!top_task(t)) return 1'b0;
    if (t == cur_task) return 1'b0;
    cur_task = t;
    return 1'b1;
  endfunction

  function automatic void tick_tasks();
    int i, p;
    logic [2:0] t;
    i = 0;
    while (i < slp_len) begin
      t = slp_q[i];
      sleep_cnt[t] = sleep_cnt[t] - 16'd1;
      if (sleep_cnt[t] == 0) begin
        slp_del(i);
        rdy_push_head(t);
      end else begin
        i++;
      end
    end
    slice_cnt[cur_task] = slice_cnt[cur_task] - 8'd1;
    if (slice_cnt[cur_task] == 0) begin
      p = task_prio[cur_task];
      if (rdy_len[p] > 1 && rdy_q[p][0] == cur_task) begin
        rdy_del(p, 0);
        rdy_q[p][rdy_len[p]] = cur_task;
        rdy_len[p]++;
      end
      slice_cnt[cur_task] = slice_len;
    end
  endfunction

  function automatic sched_res_t apply_op(prs_pkg::op_e op, int t, int prio,
                                          logic [15:0] dly);
    sched_res_t r;
    logic sw;
    logic [2:0] nt;
    sw = 1'b0;
    case (op)
      prs_pkg::OP_TICK: begin
        tick_tasks();
        sw = pick_task(1'b0);
      end
      prs_pkg::OP_DELAY: begin
        slp_drop(cur_task);
        if (slp_len < NTASK) begin
          for (int j = slp_len; j > 0; j--) slp_q[j] = slp_q[j-1];
          slp_q[0] = cur_task;
          slp_len++;
        end
        sleep_cnt[cur_task] = dly;
        rdy_drop(cur_task);
        sw = pick_task(1'b0);
      end
      prs_pkg::OP_LOCK: if (lock_cnt < prs_pkg::LOCK_MAX) lock_cnt++;
      prs_pkg::OP_UNLOCK: begin
        if (lock_cnt > 0) begin
          lock_cnt--;
          if (lock_cnt == 0) sw = pick_task(1'b0);
        end
      end
      prs_pkg::OP_ADD: begin
        if (added[t]) rdy_drop(t);
        slp_drop(t);
        task_prio[t] = 5'(prio);
        slice_cnt[t] = slice_len;
        sleep_cnt[t] = '0;
        added[t] = 1'b1;
        rdy_push_head(t);
      end
      prs_pkg::OP_READY: rdy_push_head(t);
      prs_pkg::OP_UNREADY: rdy_drop(t);
      default: sw = pick_task(1'b1);
    endcase
    r.any = top_task(nt);
    r.nxt = nt;
    r.sw = sw;
    r.run = cur_task;
    r.lk = lock_cnt;
    return r;
  endfunction

  task automatic send_word(prs_pkg::op_e op, logic [2:0] id, logic [4:0] prio,
                           logic [15:0] dly, int gap, bit typed, sched_res_t typed_res);
    sched_res_t r;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    op_i <= op;
    task_id_i <= id;
    task_priority_i <= prio;
    delay_ticks_i <= dly;
    do @(posedge clk_i); while (!in_ready);
    r = apply_op(op, id, prio, dly);
    pending_q.push_back(typed ? typed_res : r);
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_slice(logic [7:0] v);
    go_idle();
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    slice_len = v;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  function automatic int rand_gap();
    int k;
    k = $urandom_range(0, 9);
    if (k < 6) return 0;
    if (k < 9) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_random();
    prs_pkg::op_e op;
    int k;
    logic [2:0] id;
    logic [4:0] prio;
    logic [15:0] dly;
    sched_res_t none;
    none = '{default: '0};
    id = 3'($urandom);
    prio = 5'($urandom);
    dly = 16'($urandom);
    k = $urandom_range(0, 99);
    if (k < 30) op = prs_pkg::OP_TICK;
    else if (k < 40) op = prs_pkg::OP_DELAY;
    else if (k < 46) op = prs_pkg::OP_LOCK;
    else if (k < 54) op = prs_pkg::OP_UNLOCK;
    else if (k < 66) op = prs_pkg::OP_ADD;
    else if (k < 78) op = prs_pkg::OP_READY;
    else if (k < 88) op = prs_pkg::OP_UNREADY;
    else op = prs_pkg::OP_START;
    if (op == prs_pkg::OP_ADD && $urandom_range(0, 3) != 0) prio = 5'($urandom_range(0, 3));
    if (op == prs_pkg::OP_READY || op == prs_pkg::OP_UNREADY) begin
      do id = 3'($urandom); while (!added[id]);
    end
    if (op == prs_pkg::OP_DELAY) begin
      k = $urandom_range(0, 19);
      if (k == 0) dly = 16'd0;
      else if (k == 1) dly = 16'hFFFF;
      else dly = 16'($urandom_range(1, 6));
    end
    send_word(op, id, prio, dly, rand_gap(), 1'b0, none);
  endtask

  localparam int NROWS = 25;
  sched_row_t rows [NROWS] = '{
    '{prs_pkg::OP_LOCK,    3'd0, 5'd0,  16'd0,    1'b1, '{3'd0, 1'b0, 1'b0, 3'd0, 8'd1}},
    '{prs_pkg::OP_UNLOCK,  3'd0, 5'd0,  16'd0,    1'b1, '{3'd0, 1'b0, 1'b0, 3'd0, 8'd0}},
    '{prs_pkg::OP_UNLOCK,  3'd5, 5'd31, 16'hFFFF, 1'b1, '{3'd0, 1'b0, 1'b0, 3'd0, 8'd0}},
    '{prs_pkg::OP_START,   3'd7, 5'd31, 16'hFFFF, 1'b1, '{3'd0, 1'b0, 1'b0, 3'd0, 8'd0}},
    '{prs_pkg::OP_ADD,     3'd0, 5'd31, 16'd0,    1'b1, '{3'd0, 1'b0, 1'b1, 3'd0, 8'd0}},
    '{prs_pkg::OP_ADD,     3'd7, 5'd0,  16'd0,    1'b1, '{3'd7, 1'b0, 1'b1, 3'd0, 8'd0}},
    '{prs_pkg::OP_START,   3'd0, 5'd0,  16'd0,    1'b1, '{3'd7, 1'b1, 1'b1, 3'd7, 8'd0}},
    '{prs_pkg::OP_ADD,     3'd3, 5'd0,  16'd0,    1'b0, '{default: '0}},
    '{prs_pkg::OP_TICK,    3'd0, 5'd0,  16'd0,    1'b0, '{default: '0}},
    '{prs_pkg::OP_READY,   3'd3, 5'd0,  16'd0,    1'b0, '{default: '0}},
    '{prs_pkg::OP_DELAY,   3'd0, 5'd0,  16'd0,    1'b0, '{default: '0}},
    '{prs_pkg::OP_DELAY,   3'd0, 5'd0,  16'hFFFF, 1'b0, '{default: '0}},
    '{prs_pkg::OP_UNREADY, 3'd0, 5'd0,  16'd0,    1'b0, '{default: '0}},
    '{prs_pkg::OP_READY,   3'd0, 5'd0,  16'd0,    1'b0, '{default: '0}},
    '{prs_pkg::OP_ADD,     3'd7, 5'd31, 16'd0,    1'b0, '{default: '0}},
    '{prs_pkg::OP_ADD,     3'd1, 5'd31, 16'd0,    1'b0, '{default: '0}},
    '{prs_pkg::OP_LOCK,    3'd0, 5'd0,  16'd0,    1'b0, '{default: '0}},
    '{prs_pkg::OP_TICK,    3'd0, 5'd0,  16'd0,    1'b0, '{default: '0}},
    '{prs_pkg::OP_UNLOCK,  3'd0, 5'd0,  16'd0,    1'b0, '{default: '0}},
    '{prs_pkg::OP_START,   3'd0, 5'd0,  16'd0,    1'b0, '{default: '0}},
    '{prs_pkg::OP_DELAY,   3'd0, 5'd0,  16'd2,    1'b0, '{default: '0}},
    '{prs_pkg::OP_TICK,    3'd0, 5'd0,  16'd0,    1'b0, '{default: '0}},
    '{prs_pkg::OP_TICK,    3'd0, 5'd0,  16'd0,    1'b0, '{default: '0}},
    '{prs_pkg::OP_UNREADY, 3'd7, 5'd0,  16'd0,    1'b0, '{default: '0}},
    '{prs_pkg::OP_TICK,    3'd0, 5'd0,  16'd0,    1'b0, '{default: '0}}
  };

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    int k;
    if (hold_req) begin
      out_ready <= 1'b0;
      repeat (300) @(negedge clk_i);
      hold_req = 1'b0;
    end else begin
      k = $urandom_range(0, 99);
      if (k < 70 || (cycles / 500) % 4 == 0) begin
        out_ready <= 1'b1;
      end else if (k < 97) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(negedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    sched_res_t e;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result word at cycle %0d", cycles);
      end else begin
        e = pending_q.pop_front();
        if (next_task_o !== e.nxt || switch_request_o !== e.sw || any_ready_o !== e.any ||
            running_task_o !== e.run || lock_depth_o !== e.lk) begin
          errors++;
          if (errors <= 10)
            $display("Mismatch: expected nxt %0d sw %0d any %0d run %0d lock %0d, got %0d %0d %0d %0d %0d",
                     e.nxt, e.sw, e.any, e.run, e.lk, next_task_o, switch_request_o,
                     any_ready_o, running_task_o, lock_depth_o);
        end
      end
    end
  end

  initial begin
    sched_res_t none;
    logic [7:0] slices [4];
    none = '{default: '0};
    slice_len = 8'(prs_pkg::SLICE_RESET);
    foreach (rdy_len[p]) rdy_len[p] = 0;
    foreach (sleep_cnt[t]) sleep_cnt[t] = '0;
    slp_len = 0;
    cur_task = '0;
    lock_cnt = '0;
    added = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < NROWS; i++)
      send_word(rows[i].op, rows[i].id, rows[i].prio, rows[i].dly, rand_gap(),
                rows[i].typed, rows[i].res);

    slices = '{8'd1, 8'd255, 8'd3, 8'd0};
    slices[3] = 8'($urandom_range(1, 255));
    for (int ph = 0; ph < 4; ph++) begin
      write_slice(slices[ph]);
      if (ph == 1) begin
        hold_req = 1'b1;
        for (int i = 0; i < 257; i++)
          send_word(prs_pkg::OP_LOCK, 3'($urandom), 5'($urandom), 16'($urandom), 0,
                    1'b0, none);
        for (int i = 0; i < 257; i++)
          send_word(prs_pkg::OP_UNLOCK, 3'($urandom), 5'($urandom), 16'($urandom),
                    rand_gap(), 1'b0, none);
      end
      for (int i = 0; i < 130; i++) send_random();
    end

    go_idle();
    if (errors == 0 && pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
